// ===== hdl/hbcr_pkg.sv =====
package hbcr_pkg;

    // Screen memory layout, in bytes from the start of the screen image.
    localparam int unsigned BITMAP_BYTES = 6144;
    localparam int unsigned SCREEN_BYTES = 6912;

    // Cell grid: 128 columns of two pixels, 96 rows of two pixel rows.
    localparam int unsigned CELL_ROWS    = 96;
    localparam int unsigned CELL_COL_W   = 7;
    localparam int unsigned CELL_ROW_W   = 7;
    localparam int unsigned OFFSET_W     = 13;

    // One bitmap word holds the even and the odd pixel row of one cell row.
    localparam int unsigned BM_WORDS     = 3072;
    localparam int unsigned BM_IDX_W     = 12;
    localparam int unsigned ATTR_WORDS   = 768;
    localparam int unsigned ATTR_IDX_W   = 10;

    localparam logic [4:0] NO_COLOR      = 5'd31;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    localparam logic [3:0] PAL_NORMAL [8] = '{4'd0, 4'd4, 4'd1, 4'd5, 4'd2, 4'd6, 4'd3, 4'd7};
    localparam logic [3:0] PAL_BRIGHT [8] =
        '{4'd8, 4'd12, 4'd9, 4'd13, 4'd10, 4'd14, 4'd11, 4'd15};

    typedef struct packed {
        logic                  func;
        logic [OFFSET_W-1:0]   mem_offset;
        logic [7:0]            mem_data;
        logic [CELL_COL_W-1:0] cell_col;
        logic [CELL_ROW_W-1:0] cell_row;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] top_color;
        logic [3:0] bottom_color;
        logic       top_changed;
        logic       bottom_changed;
    } t_out_beat;

    // Read request from the render front end to the screen memory.
    typedef struct packed {
        logic                  en;
        logic [CELL_ROW_W-1:0] row;
        logic [4:0]            col_char;
    } t_rd_req;

    // Write request into the screen memory.
    typedef struct packed {
        logic                en;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          data;
    } t_wr_req;

endpackage

// ===== hdl/hbcr_screen_mem.sv =====
module hbcr_screen_mem (
    input  logic             i_clk,
    input  hbcr_pkg::t_wr_req i_wr,
    input  hbcr_pkg::t_rd_req i_rd,
    output logic [15:0]      o_bm_word,
    output logic [7:0]       o_attr
);
    import hbcr_pkg::*;

    // Bitmap word: low byte is the even pixel row, high byte the odd one.
    logic [15:0] r_bm_mem   [BM_WORDS];
    logic [7:0]  r_attr_mem [ATTR_WORDS];
    logic [15:0] r_bm_q;
    logic [7:0]  r_attr_q;

    logic                  wr_bm;
    logic                  wr_attr;
    logic [BM_IDX_W-1:0]   wr_bm_idx;
    logic [ATTR_IDX_W-1:0] wr_attr_idx;
    logic [BM_IDX_W-1:0]   rd_bm_idx;
    logic [ATTR_IDX_W-1:0] rd_attr_idx;

    // The interleaved offset splits into character row (12:11, 7:5), pixel
    // row within the character (10:8) and byte column (4:0). Bit 8 is the
    // pixel row parity and picks the byte lane.
    always_comb begin
        wr_bm       = i_wr.en && (i_wr.offset < OFFSET_W'(BITMAP_BYTES));
        wr_attr     = i_wr.en && (i_wr.offset >= OFFSET_W'(BITMAP_BYTES))
                      && (i_wr.offset < OFFSET_W'(SCREEN_BYTES));
        wr_bm_idx   = {i_wr.offset[12:11], i_wr.offset[7:5], i_wr.offset[10:9],
                       i_wr.offset[4:0]};
        wr_attr_idx = i_wr.offset[ATTR_IDX_W-1:0];
        rd_bm_idx   = {i_rd.row, i_rd.col_char};
        rd_attr_idx = {i_rd.row[CELL_ROW_W-1:2], i_rd.col_char};
    end

    always_ff @(posedge i_clk) begin
        if (wr_bm) begin
            if (i_wr.offset[8]) begin
                r_bm_mem[wr_bm_idx][15:8] <= i_wr.data;
            end else begin
                r_bm_mem[wr_bm_idx][7:0] <= i_wr.data;
            end
        end
        if (i_rd.en) begin
            r_bm_q <= r_bm_mem[rd_bm_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_attr) begin
            r_attr_mem[wr_attr_idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_attr_q <= r_attr_mem[rd_attr_idx];
        end
    end

    assign o_bm_word = r_bm_q;
    assign o_attr    = r_attr_q;

endmodule

// ===== hdl/half_block_cell_renderer.sv =====
// Half-block cell renderer. Write beats (func 0) load one byte of the 6912-byte
// interleaved screen image: offsets below 6144 go to the bitmap, offsets 6144 to
// 6911 to the attribute area, and anything above is dropped. Render beats
// (func 1) name one terminal cell covering a 2x2 pixel group and return one
// result beat with the palette index of the upper and lower pixel pair and a
// flag per colour that is set when it differs from the previous rendered cell;
// column 0 starts a new line and always sets both flags. Rows 96 and above
// render as normal black. Write beats produce no result. The block takes one
// beat per cycle, writes and renders in any mix, unless an output stall fills
// the read stage. The bitmap and attribute memories are read at the edge that
// accepts a render, and the colour and compare logic feeds the output register
// once the read stage may advance. The bitmap is stored as words that pair the
// even and odd pixel row of a cell row, so a cell needs a single bitmap read. A
// write is visible to a render accepted in the very next cycle. Both memories
// come out of reset with undefined contents, so the host loads the whole screen
// before rendering; only the valid and previous-colour registers are reset.
module half_block_cell_renderer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hbcr_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hbcr_pkg::t_out_beat o_out_beat
);
    import hbcr_pkg::*;

    // Read stage bookkeeping for the cell whose memory words are in flight.
    typedef struct packed {
        logic [1:0] pair_sel;
        logic       col_zero;
        logic       off_screen;
    } t_s1_info;

    logic      in_acc;
    logic      s1_move;
    logic      off_screen;
    t_rd_req   rd_req;
    t_wr_req   wr_req;
    logic [15:0] bm_word;
    logic [7:0]  attr_q;

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_s1_info  r_s1;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic [4:0] r_last_top;
    logic [4:0] n_last_top;
    logic [4:0] r_last_bottom;
    logic [4:0] n_last_bottom;

    logic [7:0] attr;
    logic [7:0] byte_top;
    logic [7:0] byte_bottom;
    logic       lit_top;
    logic       lit_bottom;
    logic [3:0] top_color;
    logic [3:0] bottom_color;

    // OR of the two pixels selected by the cell column within the byte.
    function automatic logic pair_lit(input logic [7:0] b, input logic [1:0] sel);
        logic lit;
        case (sel)
            2'd0:    lit = b[7] | b[6];
            2'd1:    lit = b[5] | b[4];
            2'd2:    lit = b[3] | b[2];
            2'd3:    lit = b[1] | b[0];
            default: lit = 1'b0;
        endcase
        return lit;
    endfunction

    function automatic logic [3:0] palette(input logic [2:0] color, input logic bright);
        return bright ? PAL_BRIGHT[color] : PAL_NORMAL[color];
    endfunction

    // The read stage may advance whenever the output register is free or is
    // being emptied in this cycle. Input is taken whenever the read stage is
    // empty or advancing, so a waiting result blocks fresh beats only once the
    // read stage is full as well.
    assign s1_move    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign off_screen = i_in_beat.cell_row >= CELL_ROW_W'(CELL_ROWS);

    always_comb begin
        rd_req.en       = in_acc && (i_in_beat.func == FUNC_RENDER) && !off_screen;
        rd_req.row      = i_in_beat.cell_row;
        rd_req.col_char = i_in_beat.cell_col[CELL_COL_W-1:2];
        wr_req.en       = in_acc && (i_in_beat.func == FUNC_WRITE);
        wr_req.offset   = i_in_beat.mem_offset;
        wr_req.data     = i_in_beat.mem_data;
    end

    hbcr_screen_mem u_screen_mem (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_bm_word (bm_word),
        .o_attr    (attr_q)
    );

    // Read stage: capture the cell position alongside the memory read.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_beat.func == FUNC_RENDER)) begin
            r_s1.pair_sel   <= i_in_beat.cell_col[1:0];
            r_s1.col_zero   <= (i_in_beat.cell_col == '0);
            r_s1.off_screen <= off_screen;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_in_ready) begin
            n_s1_valid = in_acc && (i_in_beat.func == FUNC_RENDER);
        end
    end

    // Colour stage. Rows past the screen read as zero bitmap and attribute,
    // which yields paper 0 without bright, that is normal black.
    always_comb begin
        attr         = r_s1.off_screen ? 8'd0 : attr_q;
        byte_top     = r_s1.off_screen ? 8'd0 : bm_word[7:0];
        byte_bottom  = r_s1.off_screen ? 8'd0 : bm_word[15:8];
        lit_top      = pair_lit(byte_top, r_s1.pair_sel);
        lit_bottom   = pair_lit(byte_bottom, r_s1.pair_sel);
        top_color    = palette(lit_top ? attr[2:0] : attr[5:3], attr[6]);
        bottom_color = palette(lit_bottom ? attr[2:0] : attr[5:3], attr[6]);

        n_out.top_color      = top_color;
        n_out.bottom_color   = bottom_color;
        // A line start always flags a change. A real colour never equals the
        // no-colour code, so the first cell after reset flags one as well.
        n_out.top_changed    = r_s1.col_zero || ({1'b0, top_color} != r_last_top);
        n_out.bottom_changed = r_s1.col_zero || ({1'b0, bottom_color} != r_last_bottom);

        n_out_valid   = r_out_valid && !i_out_ready;
        n_last_top    = r_last_top;
        n_last_bottom = r_last_bottom;
        if (s1_move && r_s1_valid) begin
            n_out_valid   = 1'b1;
            n_last_top    = {1'b0, top_color};
            n_last_bottom = {1'b0, bottom_color};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_top    <= NO_COLOR;
            r_last_bottom <= NO_COLOR;
        end else begin
            r_s1_valid    <= n_s1_valid;
            r_out_valid   <= n_out_valid;
            r_last_top    <= n_last_top;
            r_last_bottom <= n_last_bottom;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // A cell held in the read stage is not lost while the output stalls.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid)
        else $error("read stage dropped a cell during an output stall");

    // A line start flags both colours as changed.
    a_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1_valid && r_s1.col_zero
        |=> o_out_valid && o_out_beat.top_changed && o_out_beat.bottom_changed)
        else $error("line start did not flag both colours");

    // Rows past the screen render as normal black.
    a_off_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1_valid && r_s1.off_screen
        |=> o_out_beat.top_color == 4'd0 && o_out_beat.bottom_color == 4'd0)
        else $error("off-screen cell is not black");

    // The previous colours hold the no-colour code after reset.
    a_reset_last: assert property (@(posedge i_clk)
        !i_rst_n |=> r_last_top == NO_COLOR && r_last_bottom == NO_COLOR)
        else $error("previous colours not cleared by reset");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hbcr_pkg::*;

    // Clock, reset and the two handshake channels around the renderer.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    logic      out_ready   = 1'b0;
    t_in_beat  in_beat     = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    half_block_cell_renderer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Host beats waiting to be driven, and the cell colors that the accepted
    // render beats are owed, oldest first.
    t_in_beat  host_beats [$];
    t_out_beat colors_due [$];
    t_out_beat due_beat;

    // Our own copy of the screen image and of the previous-cell colors. The
    // previous colors are 5 bits wide so that "no color yet" differs from
    // every palette index.
    logic [7:0] screen_bitmap [BITMAP_BYTES];
    logic [7:0] screen_attr [ATTR_WORDS];
    logic [4:0] last_top    = NO_COLOR;
    logic [4:0] last_bottom = NO_COLOR;

    // Bytes the stimulus has already loaded. Screen memory is undefined
    // until written, so a render only goes out once every byte it reads is
    // loaded.
    bit          screen_loaded [SCREEN_BYTES];
    int unsigned live_beats   = 0;
    int unsigned beats_total  = 0;
    int unsigned beats_taken  = 0;

    bit mismatch_seen = 1'b0;
    bit in_taken      = 1'b0;
    int in_gap        = 0;
    int in_calm       = 0;
    int out_wait      = 0;
    int out_calm      = 0;

    // Byte offset of the bitmap byte that holds pixel (px, py). Rows are
    // interleaved: the row bits are split into third, line in character
    // and character row, and the line and character row fields swap places.
    function automatic logic [12:0] pixel_offset(logic [7:0] px, logic [7:0] py);
        return {py[7:6], py[2:0], py[5:3], px[7:3]};
    endfunction

    // A pixel pair counts as lit when either of its two pixels is set.
    function automatic logic pair_lit(logic [7:0] px, logic [7:0] py);
        logic [7:0] pixels;
        pixels = screen_bitmap[pixel_offset(px, py)];
        return (pixels & (8'hC0 >> px[2:0])) != 8'h00;
    endfunction

    // Applies one accepted host beat to the screen copy. A write lands in
    // the bitmap or the attribute area, or nowhere past the end of the
    // screen; a render works out the two colors of its cell and the change
    // flags against the previous render.
    task automatic apply_host_beat(input t_in_beat b);
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] attr;
        logic       top_lit;
        logic       bot_lit;
        logic [2:0] top_hue;
        logic [2:0] bot_hue;
        t_out_beat  colors;
        if (b.func == FUNC_WRITE) begin
            if (b.mem_offset < BITMAP_BYTES) begin
                screen_bitmap[b.mem_offset] = b.mem_data;
            end else if (b.mem_offset < SCREEN_BYTES) begin
                screen_attr[b.mem_offset - BITMAP_BYTES] = b.mem_data;
            end
        end else begin
            px      = {b.cell_col, 1'b0};
            py      = {b.cell_row, 1'b0};
            attr    = 8'h00;
            top_lit = 1'b0;
            bot_lit = 1'b0;
            // Rows below the screen read as blank pixels on a zero attribute.
            if (b.cell_row < CELL_ROWS) begin
                attr    = screen_attr[{py[7:3], px[7:3]}];
                top_lit = pair_lit(px, py);
                bot_lit = pair_lit(px, py | 8'd1);
            end
            // Lit pairs take the ink, dark pairs the paper.
            top_hue = top_lit ? attr[2:0] : attr[5:3];
            bot_hue = bot_lit ? attr[2:0] : attr[5:3];
            // The palette index is the bright bit followed by the color bits
            // reordered from (green, red, blue) to (blue, green, red).
            colors.top_color    = {attr[6], top_hue[0], top_hue[2], top_hue[1]};
            colors.bottom_color = {attr[6], bot_hue[0], bot_hue[2], bot_hue[1]};
            // Column 0 opens a new line, so nothing before it counts.
            if (b.cell_col == '0) begin
                last_top    = NO_COLOR;
                last_bottom = NO_COLOR;
            end
            colors.top_changed    = {1'b0, colors.top_color} != last_top;
            colors.bottom_changed = {1'b0, colors.bottom_color} != last_bottom;
            last_top    = {1'b0, colors.top_color};
            last_bottom = {1'b0, colors.bottom_color};
            colors_due = {colors_due, colors};
        end
    endtask

    // Queues one screen write. The render fields of the beat carry noise.
    task automatic queue_write(input int unsigned off, input logic [7:0] data);
        t_in_beat b;
        b.func       = FUNC_WRITE;
        b.mem_offset = OFFSET_W'(off);
        b.mem_data   = data;
        b.cell_col   = CELL_COL_W'($urandom);
        b.cell_row   = CELL_ROW_W'($urandom);
        host_beats = {host_beats, b};
        if (off < SCREEN_BYTES) begin
            screen_loaded[off] = 1'b1;
            live_beats++;
        end
    endtask

    task automatic load_if_blank(input int unsigned off);
        if (!screen_loaded[off]) begin
            queue_write(off, 8'($urandom));
        end
    endtask

    // Queues one render, preceded by writes of random bytes for any of the
    // three bytes it reads that are still blank. The write fields carry noise.
    task automatic queue_render(input logic [6:0] col, input logic [6:0] row);
        logic [7:0] px;
        logic [7:0] py;
        t_in_beat   b;
        px = {col, 1'b0};
        py = {row, 1'b0};
        if (row < CELL_ROWS) begin
            load_if_blank(pixel_offset(px, py));
            load_if_blank(pixel_offset(px, py | 8'd1));
            load_if_blank(BITMAP_BYTES + {py[7:3], px[7:3]});
        end
        b.func       = FUNC_RENDER;
        b.mem_offset = OFFSET_W'($urandom);
        b.mem_data   = 8'($urandom);
        b.cell_col   = col;
        b.cell_row   = row;
        host_beats = {host_beats, b};
        live_beats++;
    endtask

    // Driver. The beat on the bus is predicted at the edge that accepts it;
    // the next one goes out at the falling edge after its drawn gap. Valid
    // stays up, with the beat unchanged, until the block takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) begin
            apply_host_beat(in_beat);
            in_taken = 1'b1;
            beats_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(in_valid && !in_taken)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (host_beats.size() != 0) begin
                in_beat  <= host_beats.pop_front();
                in_valid <= 1'b1;
                // Every so often a calm stretch sends beats back to back.
                if (in_calm > 0) begin
                    in_calm--;
                end else if ($urandom_range(0, 39) == 0) begin
                    in_calm = $urandom_range(8, 40);
                end
                in_gap = (in_calm > 0) ? 0 : $urandom_range(0, 17);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Each result beat is checked field by field against the
    // oldest owed colors, and a fresh stall is drawn for the next one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (colors_due.size() == 0) begin
                $error("result beat with nothing owed: %p", o_out_beat);
                mismatch_seen = 1'b1;
            end else begin
                due_beat = colors_due.pop_front();
                if (o_out_beat.top_color !== due_beat.top_color) begin
                    $error("top_color: expected %0d, actual %0d",
                           due_beat.top_color, o_out_beat.top_color);
                    mismatch_seen = 1'b1;
                end
                if (o_out_beat.bottom_color !== due_beat.bottom_color) begin
                    $error("bottom_color: expected %0d, actual %0d",
                           due_beat.bottom_color, o_out_beat.bottom_color);
                    mismatch_seen = 1'b1;
                end
                if (o_out_beat.top_changed !== due_beat.top_changed) begin
                    $error("top_changed: expected %0d, actual %0d",
                           due_beat.top_changed, o_out_beat.top_changed);
                    mismatch_seen = 1'b1;
                end
                if (o_out_beat.bottom_changed !== due_beat.bottom_changed) begin
                    $error("bottom_changed: expected %0d, actual %0d",
                           due_beat.bottom_changed, o_out_beat.bottom_changed);
                    mismatch_seen = 1'b1;
                end
            end
            if (out_calm > 0) begin
                out_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                out_calm = $urandom_range(8, 40);
            end
            out_wait = (out_calm > 0) ? 0 : $urandom_range(0, 17);
        end
    end

    // Ready is held low for the drawn stall, whether or not a result is
    // waiting, so stalls land on every phase of the pipeline.
    always @(negedge i_clk) begin
        if (out_wait > 0) begin
            out_wait--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        int         pick;
        logic [6:0] run_col;
        logic [6:0] run_row;

        // Directed part. Cell (0,0) gets a lit upper pair on the left and
        // cell (1,0) a lit lower pair, under a bright attribute with
        // different ink and paper.
        queue_write(0, 8'hC0);
        queue_write(256, 8'h30);
        queue_write(BITMAP_BYTES, 8'h6A);
        queue_render(0, 0);
        queue_render(1, 0);
        // Same colors again in mid-line: both change flags drop.
        queue_render(1, 0);
        // Line start always flags both colors, even when they repeat.
        queue_render(0, 0);
        queue_render(0, 0);
        // Writes past the end of the screen are dropped.
        queue_write(SCREEN_BYTES, 8'hFF);
        queue_write(8191, 8'h00);
        // Flash, bright, white on white: the flash bit plays no part.
        queue_write(BITMAP_BYTES, 8'hFF);
        queue_render(2, 0);
        queue_write(0, 8'h00);
        queue_render(0, 0);
        // Last byte of the bitmap and of the attribute area, last cell.
        queue_write(pixel_offset(8'd254, 8'd190), 8'h03);
        queue_write(BITMAP_BYTES - 1, 8'hFF);
        queue_write(SCREEN_BYTES - 1, 8'h00);
        queue_render(127, 95);
        // Rows below the screen render black and still move the flags.
        queue_render(127, 96);
        queue_render(127, 127);
        queue_render(0, 127);
        // A cell out of order, then one far away.
        queue_render(64, 48);
        queue_render(3, 0);

        // Random part. Mostly runs of cells along a line, with line starts
        // common, an occasional repeated cell and wrap past column 127;
        // around them stray renders and overwrites of screen bytes, some of
        // them past the end of the screen.
        while (live_beats < 1050) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                if ($urandom_range(0, 5) == 0) begin
                    queue_write($urandom_range(SCREEN_BYTES, 8191), 8'($urandom));
                end else begin
                    queue_write($urandom_range(0, SCREEN_BYTES - 1), 8'($urandom));
                end
            end else if (pick == 2) begin
                queue_render(7'($urandom), 7'($urandom));
            end else begin
                run_row = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(96, 127))
                                                      : 7'($urandom_range(0, 95));
                run_col = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(0, 127));
                repeat ($urandom_range(1, 24)) begin
                    queue_render(run_col, run_row);
                    if ($urandom_range(0, 7) != 0) begin
                        run_col++;
                    end
                end
            end
        end
        beats_total = host_beats.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < beats_total) @(posedge i_clk);
        while (colors_due.size() != 0) @(posedge i_clk);
        // Wait well past the last owed result so that a stray extra result
        // would still be caught.
        repeat (16) @(posedge i_clk);

        if (!mismatch_seen) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: a correct run with every gap and stall at its longest ends
    // well inside this.
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
